>>> hdl/sample_bin_averager_core_defines.svh
`ifndef SAMPLE_BIN_AVERAGER_CORE_DEFINES_SVH
`define SAMPLE_BIN_AVERAGER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SBA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sba_pkg.sv
package sba_pkg;

  localparam int MAX_BINS    = 128;
  localparam int COUNT_WIDTH = 16;
  localparam int SUM_WIDTH   = 48;
  localparam int DATA_W      = 32;
  localparam int OUT_COUNT_W = 16;
  localparam int BIN_AW      = $clog2(MAX_BINS);
  localparam int NB_W        = $clog2(MAX_BINS + 1);

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_MIN_X     = 2'd0,
    CFG_BIN_SCALE = 2'd1,
    CFG_NUM_BINS  = 2'd2,
    CFG_CUT_BINS  = 2'd3
  } cfg_t;

  // write port of the bin memory
  typedef struct packed {
    logic                   en;
    logic [BIN_AW-1:0]      addr;
    logic [COUNT_WIDTH-1:0] count;
    logic [SUM_WIDTH-1:0]   sum;
  } bin_wr_t;

  // zero acts as one, anything above the memory depth acts as the depth
  function automatic logic [NB_W-1:0] bins_in_use(input logic [7:0] n);
    logic [NB_W-1:0] r;
    if (n == 8'd0) begin
      r = NB_W'(1);
    end else if (int'(n) > MAX_BINS) begin
      r = NB_W'(MAX_BINS);
    end else begin
      r = NB_W'(n);
    end
    return r;
  endfunction

  function automatic logic [OUT_COUNT_W-1:0] clip_count(input logic [COUNT_WIDTH-1:0] c);
    logic [COUNT_WIDTH+OUT_COUNT_W-1:0] wide;
    logic [COUNT_WIDTH+OUT_COUNT_W-1:0] lim;
    wide = {{OUT_COUNT_W{1'b0}}, c};
    lim  = {{COUNT_WIDTH{1'b0}}, {OUT_COUNT_W{1'b1}}};
    if (wide > lim) begin
      return {OUT_COUNT_W{1'b1}};
    end
    return wide[OUT_COUNT_W-1:0];
  endfunction

endpackage

>>> hdl/sba_bin_mem.sv
module sba_bin_mem
  import sba_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   clear_all,
  input  logic                   rd_en,
  input  logic [BIN_AW-1:0]      rd_addr,
  output logic [COUNT_WIDTH-1:0] rd_count,
  output logic [SUM_WIDTH-1:0]   rd_sum,
  input  bin_wr_t                wr
);

  localparam int ENTRY_W = COUNT_WIDTH + SUM_WIDTH;

  logic [ENTRY_W-1:0]  mem [MAX_BINS];
  logic [MAX_BINS-1:0] valid;
  logic [ENTRY_W-1:0]  rd_q;
  logic                rd_valid_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= {wr.count, wr.sum};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q       <= mem[rd_addr];
      rd_valid_q <= valid[rd_addr];
    end
  end

  // valid bits stand in for the zero state of every bin
  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  assign rd_count = rd_valid_q ? rd_q[ENTRY_W-1:SUM_WIDTH] : '0;
  assign rd_sum   = rd_valid_q ? rd_q[SUM_WIDTH-1:0] : '0;

endmodule

>>> hdl/sba_divider.sv
module sba_divider
  import sba_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [SUM_WIDTH-1:0]   dividend,
  input  logic [COUNT_WIDTH-1:0] divisor,
  output logic                   done,
  output logic [DATA_W-1:0]      quotient
);

  localparam int STEP_W = $clog2(SUM_WIDTH);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_WIDTH - 1);
  localparam logic [SUM_WIDTH-1:0] POS_LIM =
    {{(SUM_WIDTH-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic [SUM_WIDTH-1:0] NEG_LIM =
    {{(SUM_WIDTH-DATA_W){1'b0}}, 1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_RUN  = 3'b010,
    DIV_DONE = 3'b100
  } div_state_t;

  div_state_t             state;
  logic [STEP_W-1:0]      step;
  logic [COUNT_WIDTH-1:0] rem;
  logic [COUNT_WIDTH-1:0] dvs;
  logic [SUM_WIDTH-1:0]   quo;
  logic                   neg;
  logic [COUNT_WIDTH:0]   shifted;
  logic                   fits;
  logic [COUNT_WIDTH:0]   diff;

  // one restoring step per cycle on the magnitude
  assign shifted = {rem, quo[SUM_WIDTH-1]};
  assign fits    = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        DIV_IDLE: if (start) state <= DIV_RUN;
        DIV_RUN:  if (step == LAST_STEP) state <= DIV_DONE;
        DIV_DONE: begin
          state <= DIV_IDLE;
          done  <= 1'b1;
        end
        default:  state <= DIV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      DIV_IDLE: begin
        if (start) begin
          neg  <= dividend[SUM_WIDTH-1];
          quo  <= dividend[SUM_WIDTH-1] ? (~dividend + SUM_WIDTH'(1)) : dividend;
          rem  <= '0;
          dvs  <= divisor;
          step <= '0;
        end
      end
      DIV_RUN: begin
        rem  <= fits ? diff[COUNT_WIDTH-1:0] : shifted[COUNT_WIDTH-1:0];
        quo  <= {quo[SUM_WIDTH-2:0], fits};
        step <= step + STEP_W'(1);
      end
      DIV_DONE: begin
        // clamp to the signed output range, then apply the sign
        if (!neg && quo > POS_LIM) begin
          quotient <= {1'b0, {(DATA_W-1){1'b1}}};
        end else if (neg && quo > NEG_LIM) begin
          quotient <= {1'b1, {(DATA_W-1){1'b0}}};
        end else if (neg) begin
          quotient <= ~quo[DATA_W-1:0] + DATA_W'(1);
        end else begin
          quotient <= quo[DATA_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

>>> hdl/sample_bin_averager_core.sv
// path from input transaction to result: add sample goes diff, mul, look, rmw, out (no rmw
// when out of range); clear, no-op or out-of-use read look, out; empty-bin read look, rmw,
// out; filled-bin read look, rmw, div, out. One item at a time, taken in idle once the last
// result loads (out_ready may stall it); read bound by the 48-step divider, add by the rmw
// reset: synchronous; control and config registers take defaults, all bins read empty at once
// through per-bin valid bits, so no clearing pass follows reset
`include "sample_bin_averager_core_defines.svh"

module sample_bin_averager_core
  import sba_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // item channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             command,
  input  logic [31:0]            sample_x,
  input  logic [31:0]            sample_y,
  input  logic [6:0]             read_index,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [DATA_W-1:0]      bin_mean,
  output logic [OUT_COUNT_W-1:0] bin_count,
  output logic                   subject_valid,
  output logic [1:0]             status,
  // configuration channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data
);

  localparam int IW = ((NB_W > 6) ? NB_W : 6) + 1;

  // one-hot sequencer: add walks diff, mul, look, rmw if in range; read walks look, rmw if in use, div if filled
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIFF = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_LOOK = 7'b0001000,
    S_RMW  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state;

  // configuration registers
  logic [31:0] min_x;
  logic [31:0] bin_scale;
  logic [7:0]  num_bins;
  logic [5:0]  cut_bins;

  // captured transaction
  cmd_t        cmd_q;
  logic [31:0] x_q;
  logic [31:0] y_q;
  logic [6:0]  idx_q;

  // add-sample datapath
  logic [32:0] diff;
  logic        neg_q;
  logic [31:0] dmag_q;
  logic [63:0] prod;
  logic [31:0] bin_q;

  // pending result
  logic [DATA_W-1:0]      res_mean;
  logic [OUT_COUNT_W-1:0] res_count;
  status_t                res_status;

  logic interior_hit;

  logic [NB_W-1:0]        nb;
  logic                   add_in_range;
  logic                   read_in_use;
  logic                   interior_bin;
  logic                   mem_rd_en;
  logic [BIN_AW-1:0]      mem_rd_addr;
  logic                   mem_clear;
  logic [COUNT_WIDTH-1:0] mem_count;
  logic [SUM_WIDTH-1:0]   mem_sum;
  bin_wr_t                mem_wr;
  logic                   bin_full;
  logic                   div_start;
  logic                   div_done;
  logic [DATA_W-1:0]      div_quot;
  logic                   out_load;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign nb = bins_in_use(num_bins);

  // x - min_x in 33 bits so the sign is exact
  assign diff = {x_q[31], x_q} - {min_x[31], min_x};
  // bin = floor(d * scale / 2^32), one 32x32 product
  assign prod = {32'b0, dmag_q} * {32'b0, bin_scale};

  assign add_in_range = !neg_q && (bin_q < 32'(nb));
  assign read_in_use  = 32'(idx_q) < 32'(nb);

  // interior when cut <= bin and bin + cut < bins in use
  assign interior_bin = (IW'(bin_q[BIN_AW-1:0]) >= IW'(cut_bins)) &&
                        ((IW'(bin_q[BIN_AW-1:0]) + IW'(cut_bins)) < IW'(nb));

  // memory read is issued from the look step, data arrives in rmw
  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = bin_q[BIN_AW-1:0];
    if (state == S_LOOK) begin
      if (cmd_q == CMD_ADD) begin
        mem_rd_en = add_in_range;
      end else if (cmd_q == CMD_READ) begin
        mem_rd_en   = read_in_use;
        mem_rd_addr = BIN_AW'(idx_q);
      end
    end
  end

  assign mem_clear = (state == S_LOOK) && (cmd_q == CMD_CLEAR);

  // a full bin drops the sample entirely
  assign bin_full = (mem_count == {COUNT_WIDTH{1'b1}});

  always_comb begin
    mem_wr.en    = (state == S_RMW) && (cmd_q == CMD_ADD) && !bin_full;
    mem_wr.addr  = bin_q[BIN_AW-1:0];
    mem_wr.count = mem_count + COUNT_WIDTH'(1);
    // sum wraps in its own width
    mem_wr.sum   = mem_sum + {{(SUM_WIDTH-32){y_q[31]}}, y_q};
  end

  assign div_start = (state == S_RMW) && (cmd_q == CMD_READ) && (mem_count != '0);

  // output register frees the result side from the sequencer
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  sba_bin_mem u_mem (
    .clk       (clk),
    .rst       (rst),
    .clear_all (mem_clear),
    .rd_en     (mem_rd_en),
    .rd_addr   (mem_rd_addr),
    .rd_count  (mem_count),
    .rd_sum    (mem_sum),
    .wr        (mem_wr)
  );

  sba_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mem_sum),
    .divisor  (mem_count),
    .done     (div_done),
    .quotient (div_quot)
  );

  // control state, configuration and subject flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      interior_hit <= 1'b0;
      min_x        <= 32'd0;
      bin_scale    <= 32'd65536;
      num_bins     <= 8'd128;
      cut_bins     <= 6'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_t'(cfg_index))
          CFG_MIN_X:     min_x     <= cfg_data;
          CFG_BIN_SCALE: bin_scale <= cfg_data;
          CFG_NUM_BINS:  num_bins  <= cfg_data[7:0];
          CFG_CUT_BINS:  cut_bins  <= cfg_data[5:0];
          default:       ;
        endcase
      end

      // a new result replaces the one leaving in the same cycle
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= (cmd_t'(command) == CMD_ADD) ? S_DIFF : S_LOOK;
          end
        end
        S_DIFF: state <= S_MUL;
        S_MUL:  state <= S_LOOK;
        S_LOOK: begin
          if (mem_clear) begin
            interior_hit <= 1'b0;
          end
          state <= mem_rd_en ? S_RMW : S_OUT;
        end
        S_RMW: begin
          if (mem_wr.en && interior_bin) begin
            interior_hit <= 1'b1;
          end
          state <= div_start ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd_q <= cmd_t'(command);
      x_q   <= sample_x;
      y_q   <= sample_y;
      idx_q <= read_index;
    end
    if (state == S_DIFF) begin
      neg_q  <= diff[32];
      dmag_q <= diff[31:0];
    end
    if (state == S_MUL) begin
      bin_q <= prod[63:32];
    end
    if (state == S_LOOK) begin
      res_mean   <= '0;
      res_count  <= '0;
      res_status <= (cmd_q == CMD_ADD && !add_in_range) ? ST_RANGE : ST_OK;
    end
    if (state == S_RMW) begin
      if (cmd_q == CMD_ADD && bin_full) begin
        res_status <= ST_SAT;
      end
      if (cmd_q == CMD_READ) begin
        res_count <= clip_count(mem_count);
      end
    end
    if (state == S_DIV && div_done) begin
      res_mean <= div_quot;
    end
    if (out_load) begin
      bin_mean      <= res_mean;
      bin_count     <= res_count;
      subject_valid <= interior_hit;
      status        <= res_status;
    end
  end

  `SBA_ASSERT_SAME(a_div_done_waiting, div_done, state == S_DIV, "divider finished while not awaited")
  `SBA_ASSERT_SAME(a_wr_in_rmw, mem_wr.en, state == S_RMW && cmd_q == CMD_ADD, "bin write outside add step")
  `SBA_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state != S_IDLE, "accepted transaction not started")

endmodule
